// File: rtl/core/sha1_pkg.sv
// sha1 package: constants and types used by the front, queue and back parts
// no dependencies
package sha1_pkg;
   localparam logic [31:0] K0 = 32'h5a827999;
   localparam logic [31:0] K1 = 32'h6ed9eba1;
   localparam logic [31:0] K2 = 32'h8f1bbcdc;
   localparam logic [31:0] K3 = 32'hca62c1d6;
   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hefcdab89;
   localparam logic [31:0] H2 = 32'h98badcfe;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hc3d2e1f0;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam int unsigned QUEUE_DEPTH = 2;

   // one block handed from front to back
   typedef struct packed {
      logic [511:0] words;
      logic         final_blk;
   } blk_type;
endpackage

// File: rtl/core/sha1_front.sv
// sha1 front part: packs bytes into blocks, pads at end of message
// depends on sha1_pkg
module sha1_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic              in_has,
   input  logic              in_last,
   output logic              blk_valid,
   input  logic              blk_ready,
   output sha1_pkg::blk_type blk
);
   import sha1_pkg::*;

   typedef enum logic [2:0] {FILL, PAD, ZERO, LEN, EMIT} state_type;

   state_type    state_ff;
   state_type    resume_ff;
   logic [511:0] buf_ff;
   logic [5:0]   fill_ff;
   logic [63:0]  count_ff;
   logic         final_ff;

   logic [7:0]   put_byte;
   logic [8:0]   bit_pos;
   logic [5:0]   len_pos;
   logic [511:0] buf_in;

   always_comb begin
      unique case (state_ff)
         FILL:    put_byte = in_byte;
         PAD:     put_byte = PAD_BYTE;
         ZERO:    put_byte = 8'd0;
         LEN:     put_byte = count_ff[len_pos +: 8];
         EMIT:    put_byte = 8'd0;
         default: put_byte = 8'd0;
      endcase
   end

   // length bytes go out most significant first at positions 56..63
   assign len_pos = {~fill_ff[2:0], 3'b000};
   assign bit_pos = 9'd504 - {fill_ff, 3'b000};
   always_comb begin
      buf_in = buf_ff;
      buf_in[bit_pos +: 8] = put_byte;
   end

   assign in_ready  = (state_ff == FILL);
   assign blk_valid = (state_ff == EMIT);
   assign blk.words = buf_ff;
   assign blk.final_blk = final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FILL;
         resume_ff <= FILL;
         fill_ff   <= 6'd0;
         count_ff  <= 64'd0;
         final_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            FILL: begin
               if (in_valid) begin
                  if (in_has) begin
                     buf_ff   <= buf_in;
                     fill_ff  <= fill_ff + 6'd1;
                     count_ff <= count_ff + 64'd8;
                  end
                  if (in_has && fill_ff == 6'd63) begin
                     // block full, pad byte still owed if the message ends here
                     state_ff <= EMIT;
                     if (in_last) resume_ff <= PAD;
                     else resume_ff <= FILL;
                  end else if (in_last) begin
                     state_ff <= PAD;
                  end
               end
            end
            PAD, ZERO: begin
               buf_ff  <= buf_in;
               fill_ff <= fill_ff + 6'd1;
               if (fill_ff == 6'd63) begin
                  // no room for the length, go on in a fresh block
                  state_ff  <= EMIT;
                  resume_ff <= ZERO;
               end else if (fill_ff == 6'd55) begin
                  state_ff <= LEN;
               end else begin
                  state_ff <= ZERO;
               end
            end
            LEN: begin
               buf_ff  <= buf_in;
               fill_ff <= fill_ff + 6'd1;
               if (fill_ff == 6'd63) begin
                  state_ff  <= EMIT;
                  final_ff  <= 1'b1;
                  resume_ff <= FILL;
               end
            end
            EMIT: begin
               if (blk_ready) begin
                  state_ff <= resume_ff;
                  if (final_ff) begin
                     count_ff <= 64'd0;
                     final_ff <= 1'b0;
                  end
               end
            end
            default: state_ff <= FILL;
         endcase
      end
   end
endmodule

// File: rtl/core/sha1_queue.sv
// sha1 block queue: short fifo between front and back
// depends on sha1_pkg
module sha1_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  sha1_pkg::blk_type wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output sha1_pkg::blk_type rd_data
);
   import sha1_pkg::*;

   blk_type    mem_ff [QUEUE_DEPTH];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign wr_ready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_valid && wr_ready) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr_valid && wr_ready) wp_ff <= ~wp_ff;
         if (rd_valid && rd_ready) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
      end
   end
endmodule

// File: rtl/core/sha1_back.sv
// sha1 back part: 80-round compression, one round a cycle, digest output
// depends on sha1_pkg
module sha1_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              blk_valid,
   output logic              blk_ready,
   input  sha1_pkg::blk_type blk,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [159:0]      out_digest
);
   import sha1_pkg::*;

   typedef enum logic [1:0] {IDLE, RUN, ADD} state_type;

   state_type     state_ff;
   logic [6:0]    round_ff;
   logic [31:0]   sched_ff [16];
   logic [31:0]   a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]   h_ff [5];
   logic          final_ff;
   logic          ovalid_ff;
   logic [159:0]  odig_ff;

   logic [31:0] x, w, f, k, t;

   always_comb begin
      x = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      w = (round_ff < 7'd16) ? sched_ff[0] : {x[30:0], x[31]};
      if (round_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = K0;
      end else if (round_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K1;
      end else if (round_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K3;
      end
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + w;
   end

   assign blk_ready  = (state_ff == IDLE) && !ovalid_ff;
   assign out_valid  = ovalid_ff;
   assign out_digest = odig_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         round_ff  <= 7'd0;
         ovalid_ff <= 1'b0;
         h_ff[0] <= H0; h_ff[1] <= H1; h_ff[2] <= H2; h_ff[3] <= H3; h_ff[4] <= H4;
      end else begin
         if (ovalid_ff && out_ready) ovalid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (blk_valid && !ovalid_ff) begin
                  for (int i = 0; i < 16; i++) sched_ff[i] <= blk.words[511 - 32*i -: 32];
                  a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2];
                  d_ff <= h_ff[3]; e_ff <= h_ff[4];
                  final_ff <= blk.final_blk;
                  round_ff <= 7'd0;
                  state_ff <= RUN;
               end
            end
            RUN: begin
               for (int i = 0; i < 15; i++) sched_ff[i] <= sched_ff[i+1];
               sched_ff[15] <= w;
               e_ff <= d_ff; d_ff <= c_ff; c_ff <= {b_ff[1:0], b_ff[31:2]};
               b_ff <= a_ff; a_ff <= t;
               round_ff <= round_ff + 7'd1;
               if (round_ff == 7'd79) state_ff <= ADD;
            end
            ADD: begin
               if (final_ff) begin
                  odig_ff <= {h_ff[0] + a_ff, h_ff[1] + b_ff, h_ff[2] + c_ff,
                              h_ff[3] + d_ff, h_ff[4] + e_ff};
                  ovalid_ff <= 1'b1;
                  h_ff[0] <= H0; h_ff[1] <= H1; h_ff[2] <= H2;
                  h_ff[3] <= H3; h_ff[4] <= H4;
               end else begin
                  h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
                  h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
                  h_ff[4] <= h_ff[4] + e_ff;
               end
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

// File: rtl/core/sha1_hash.sv
// sha1 top level: front packer, block queue, compression back end
// depends on sha1_pkg, sha1_front, sha1_queue, sha1_back
//
//  channel | direction | contents
//  req_    | in        | tdata = data_byte [7:0], tuser = {is_last, has_byte}
//  rsp_    | out       | tdata = digest_w0..w4, w0 in the lowest bits
//
// one byte a cycle is taken while the block is filling; a full block goes to a
// two-entry queue and the back end runs its 80 rounds on it, one round a cycle
// padding and length bytes are written one a cycle; a message end takes one or two blocks
// synchronous active-high reset returns the chaining words to their initial values
// the input stalls for the block hand-off cycle, while the queue is full and
// while padding is under way; the back end waits while a digest is unread
module sha1_hash (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic [1:0]   req_tuser,   // has_byte, is_last
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata    // digest_w0, w1, w2, w3, w4
);
   import sha1_pkg::*;

   blk_type      f_blk, q_blk;
   logic         f_valid, f_ready, q_valid, q_ready;
   logic [159:0] dig;

   sha1_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_byte(req_tdata), .in_has(req_tuser[0]), .in_last(req_tuser[1]),
      .blk_valid(f_valid), .blk_ready(f_ready), .blk(f_blk)
   );

   sha1_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_blk),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_blk)
   );

   sha1_back u_back (
      .clock, .reset,
      .blk_valid(q_valid), .blk_ready(q_ready), .blk(q_blk),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_digest(dig)
   );

   // w0 goes to the lowest bits
   assign rsp_tdata = {dig[31:0], dig[63:32], dig[95:64], dig[127:96], dig[159:128]};
endmodule
